// ----- design/qps_pkg.sv -----
// ----------------------------------------------------------------------------
// qps_pkg
// Shared types and constants of the quadrature position and speed block.
// ----------------------------------------------------------------------------
package qps_pkg;

	localparam int POSITION_BITS_DEF = 32;
	localparam int TIMER_BITS_DEF    = 32;

	localparam int PPR_W          = 16;
	localparam int MIN_INTERVAL_W = 10;
	localparam int CFG_INDEX_W    = 2;
	localparam int CFG_DATA_W     = 16;
	localparam int SPEED_W        = 32;
	localparam int OUT_POS_W      = 32;

	// 256000 = 1000 ms/s * 256 (Q.8)
	localparam int SCALE_W = 18;
	localparam logic [SCALE_W-1:0] SPEED_SCALE = 18'd256000;

	localparam logic [PPR_W-1:0]          PPR_RESET          = 16'd1;
	localparam logic [MIN_INTERVAL_W-1:0] MIN_INTERVAL_RESET = 10'd10;

	localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_REV  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL_MS = 2'd1;

	localparam logic [SPEED_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
	localparam logic [SPEED_W-1:0] SPEED_MIN = 32'h8000_0000;

	typedef enum logic [1:0] {
		STEP_NONE = 2'b00,
		STEP_UP   = 2'b01,
		STEP_DOWN = 2'b10
	} step_t;

	// index is {previous AB, current AB}
	localparam step_t STEP_TABLE [16] = '{
		STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
		STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
		STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
		STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
	};

	typedef struct packed {
		logic busy;
		logic ovf;
	} div_stat_t;

	typedef struct packed {
		logic [OUT_POS_W-1:0] pos;
		logic [SPEED_W-1:0]   speed;
		logic                 upd;
	} result_t;

endpackage

// ----- design/qps_mul.sv -----
// ----------------------------------------------------------------------------
// qps_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module qps_mul #(
	parameter int AW = 32,
	parameter int BW = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [AW-1:0]     a,
	input  logic [BW-1:0]     b,
	output logic              busy,
	output logic [AW+BW-1:0]  product
);

	logic [BW-1:0]    mplier_q;
	logic [AW+BW-1:0] mcand_q;
	logic [AW+BW-1:0] acc_q;

	assign busy    = |mplier_q;
	assign product = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mplier_q <= '0;
		end else if (start) begin
			mplier_q <= b;
		end else begin
			mplier_q <= mplier_q >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mcand_q <= {{BW{1'b0}}, a};
		end else if (busy) begin
			if (mplier_q[0]) begin
				acc_q <= acc_q + mcand_q;
			end
			mcand_q <= mcand_q << 1;
		end
	end

endmodule

// ----- design/qps_div.sv -----
// ----------------------------------------------------------------------------
// qps_div
// Bit-serial restoring divider, one quotient bit per cycle; keeps the low
// quotient bits and flags any set bit at or above the sign position.
// ----------------------------------------------------------------------------
module qps_div #(
	parameter int NW = 50,
	parameter int DW = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [NW-1:0]               num,
	input  logic [DW-1:0]               den,
	output qps_pkg::div_stat_t          stat,
	output logic [qps_pkg::SPEED_W-1:0] quo
);
	import qps_pkg::*;

	localparam int IW = $clog2(NW);

	logic              busy_q;
	logic [IW-1:0]     idx_q;
	logic [NW-1:0]     num_q;
	logic [DW-1:0]     rem_q;
	logic [SPEED_W-1:0] quo_q;
	logic              ovf_q;

	logic [DW:0] trial;
	logic [DW:0] dif;
	logic        take;

	assign trial = {rem_q, num_q[NW-1]};
	assign dif   = trial - {1'b0, den};
	assign take  = trial >= {1'b0, den};

	assign stat.busy = busy_q;
	assign stat.ovf  = ovf_q;
	assign quo       = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			idx_q  <= IW'(NW - 1);
		end else if (busy_q) begin
			if (idx_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= take ? dif[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[SPEED_W-2:0], take};
			if (take && idx_q >= IW'(SPEED_W - 1)) begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

// ----- design/quadrature_position_speed_top.sv -----
// ----------------------------------------------------------------------------
// quadrature_position_speed_top
// x4 quadrature decoder with wrapping position count and speed measurement.
// ----------------------------------------------------------------------------
// Usage:
// One input item per sampled A/B pair, with ms_tick, clear_position and
// speed_request flags; each item gives exactly one result item holding the
// position, the last speed (signed Q.8 rev/s) and an update flag.
// Items without an accepted speed update pass at one item per cycle while
// in_ready is high; their result is registered into the output stage. An
// item that starts a speed update runs two serial shift-add multiplies, for
// the numerator and the denominator, and then a serial restoring divide
// before its result is pushed, and no item is taken until it is pushed.
// Results sit in an output register backed by a one-entry skid register, so
// an item is still accepted while one result waits; with both full, in_ready
// drops until out_ready drains them.
// Reset clears position, elapsed time and speed, and sets pulses_per_rev to
// 1 and min_interval_ms to 10. The first item after reset only primes the
// stored A/B state. Configuration writes are always taken (cfg_ready high).
// ----------------------------------------------------------------------------
module quadrature_position_speed_top #(
	parameter int POSITION_BITS = qps_pkg::POSITION_BITS_DEF,
	parameter int TIMER_BITS    = qps_pkg::TIMER_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qps_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [qps_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            pin_a,
	input  logic                            pin_b,
	input  logic                            ms_tick,
	input  logic                            clear_position,
	input  logic                            speed_request,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [qps_pkg::OUT_POS_W-1:0] position,
	output logic signed [qps_pkg::SPEED_W-1:0]   speed_q8,
	output logic                            speed_updated
);
	import qps_pkg::*;

	localparam int NUM_W = POSITION_BITS + SCALE_W;
	localparam int DEN_W = TIMER_BITS + PPR_W;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_MUL  = 3'b010,
		ST_DIV  = 3'b100
	} state_t;

	state_t                    state_q;
	logic [PPR_W-1:0]          ppr_q;
	logic [MIN_INTERVAL_W-1:0] min_int_q;
	logic [1:0]                last_ab_q;
	logic                      primed_q;
	logic [POSITION_BITS-1:0]  pos_q;
	logic [POSITION_BITS-1:0]  last_pos_q;
	logic [TIMER_BITS-1:0]     elapsed_q;
	logic [SPEED_W-1:0]        speed_q;
	logic                      neg_q;
	logic [POSITION_BITS-1:0]  mag_op;
	logic [TIMER_BITS-1:0]     el_op;
	logic [PPR_W-1:0]          ppr_op;

	logic    out_valid_q;
	result_t out_q;
	logic    sk_valid_q;
	result_t sk_q;

	logic [1:0]                ab;
	step_t                     step;
	logic [POSITION_BITS-1:0]  pos_dec;
	logic [POSITION_BITS-1:0]  pos_new;
	logic [TIMER_BITS-1:0]     el_new;
	logic [MIN_INTERVAL_W-1:0] min_eff;
	logic                      spd_go;
	logic [POSITION_BITS-1:0]  diff;
	logic                      accept;
	logic                      mul_start;
	logic                      div_start;
	logic                      push_fast;
	logic                      push_slow;
	logic                      push;
	logic                      pop;
	result_t                   res;
	logic [POSITION_BITS-1:0]  res_pos_src;
	logic [POSITION_BITS+OUT_POS_W-1:0] res_pos_ext;
	logic [SPEED_W-1:0]        spd_calc;
	logic                      sat;

	logic                      num_busy;
	logic                      den_busy;
	logic [NUM_W-1:0]          num_prod;
	logic [DEN_W-1:0]          den_prod;
	div_stat_t                 div_stat;
	logic [SPEED_W-1:0]        quo;

	// decode, clear, tick, speed check
	assign ab     = {pin_a, pin_b};
	assign step   = STEP_TABLE[{last_ab_q, ab}];

	always_comb begin
		pos_dec = pos_q;
		if (primed_q) begin
			case (step)
				STEP_UP:   pos_dec = pos_q + 1'b1;
				STEP_DOWN: pos_dec = pos_q - 1'b1;
				default:   pos_dec = pos_q;
			endcase
		end
	end

	assign pos_new = clear_position ? '0 : pos_dec;
	assign el_new  = (ms_tick && elapsed_q != '1) ? elapsed_q + 1'b1 : elapsed_q;
	assign min_eff = (min_int_q == '0) ? MIN_INTERVAL_W'(1) : min_int_q;
	assign spd_go  = speed_request &&
		(el_new >= {{(TIMER_BITS - MIN_INTERVAL_W){1'b0}}, min_eff});
	assign diff    = pos_new - last_pos_q;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && !sk_valid_q;
	assign accept    = in_valid && in_ready;
	assign mul_start = accept && spd_go;
	assign div_start = (state_q == ST_MUL) && !num_busy && !den_busy;
	assign push_fast = accept && !spd_go;
	assign push_slow = (state_q == ST_DIV) && !div_stat.busy;
	assign push      = push_fast || push_slow;
	assign pop       = out_valid_q && out_ready;

	// speed sign and saturation
	assign sat      = div_stat.ovf || quo[SPEED_W-1];
	assign spd_calc = neg_q ? (sat ? SPEED_MIN : (~quo + 1'b1))
	                        : (sat ? SPEED_MAX : quo);

	assign res_pos_src = push_slow ? pos_q : pos_new;
	assign res_pos_ext = {{OUT_POS_W{1'b0}}, res_pos_src};
	assign res.pos     = res_pos_ext[OUT_POS_W-1:0];
	assign res.speed   = push_slow ? spd_calc : speed_q;
	assign res.upd     = push_slow;

	qps_mul #(
		.AW(POSITION_BITS),
		.BW(SCALE_W)
	) u_num_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mag_op),
		.b       (SPEED_SCALE),
		.busy    (num_busy),
		.product (num_prod)
	);

	qps_mul #(
		.AW(TIMER_BITS),
		.BW(PPR_W)
	) u_den_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (el_op),
		.b       (ppr_op),
		.busy    (den_busy),
		.product (den_prod)
	);

	qps_div #(
		.NW(NUM_W),
		.DW(DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_prod),
		.den    (den_prod),
		.stat   (div_stat),
		.quo    (quo)
	);

	// multiplier operands, loaded at the start edge
	always_comb begin
		mag_op = diff[POSITION_BITS-1] ? (~diff + 1'b1) : diff;
		el_op  = el_new;
		ppr_op = (ppr_q == '0) ? PPR_W'(1) : ppr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			ppr_q      <= PPR_RESET;
			min_int_q  <= MIN_INTERVAL_RESET;
			last_ab_q  <= 2'b00;
			primed_q   <= 1'b0;
			pos_q      <= '0;
			last_pos_q <= '0;
			elapsed_q  <= '0;
			speed_q    <= '0;
			neg_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PULSES_PER_REV:  ppr_q     <= cfg_data[PPR_W-1:0];
					REG_MIN_INTERVAL_MS: min_int_q <= cfg_data[MIN_INTERVAL_W-1:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						last_ab_q <= ab;
						primed_q  <= 1'b1;
						pos_q     <= pos_new;
						if (spd_go) begin
							last_pos_q <= pos_new;
							elapsed_q  <= '0;
							neg_q      <= diff[POSITION_BITS-1];
							state_q    <= ST_MUL;
						end else begin
							elapsed_q <= el_new;
						end
					end
				end
				ST_MUL: begin
					if (div_start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (push_slow) begin
						speed_q <= spd_calc;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (sk_valid_q) begin
				out_valid_q <= 1'b1;
				sk_valid_q  <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (sk_valid_q) begin
				out_q <= sk_q;
			end else if (push) begin
				out_q <= res;
			end
		end else if (push) begin
			sk_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign position      = out_q.pos;
	assign speed_q8      = out_q.speed;
	assign speed_updated = out_q.upd;

endmodule
